### design/bia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg: shared types and constants of the bitmap identifier allocator
// Word formats, status and mode codes, map geometry and the memory request
// bundle that the sequencer hands to the storage.
// ----------------------------------------------------------------------------
package bia_pkg;

  // Map geometry: storage is always 1024 words of 32 bits, arranged as
  // 32 rows of 32 words for the full-word summary level
  localparam int unsigned MAP_BYTES  = 4096;
  localparam int unsigned MAP_BITS   = MAP_BYTES * 8;
  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned ROWS       = STORE_WORDS / WORD_BITS;
  localparam int unsigned WADDR_W    = $clog2(STORE_WORDS);
  localparam int unsigned RADDR_W    = $clog2(ROWS);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam logic [16:0] MAP_BITS_W = 17'(MAP_BITS);

  // Request codes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] release_id;
  } in_word_t;

  typedef struct packed {
    logic [15:0] granted_id;
    logic [1:0]  status;
  } out_word_t;

  // One access per cycle to each of the bitmap store and the summary store
  typedef struct packed {
    logic                 data_we;
    logic [WADDR_W-1:0]   data_addr;
    logic [WORD_BITS-1:0] data_wdata;
    logic                 sum_we;
    logic [RADDR_W-1:0]   sum_addr;
    logic [WORD_BITS-1:0] sum_wdata;
  } mem_req_t;

endpackage

### design/bia_ffz.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ffz: find first zero
// Returns the position of the lowest clear bit of a 32-bit word. Shared by
// the row flags, the summary rows and the bitmap words in turn.
// ----------------------------------------------------------------------------
module bia_ffz (
  input  logic [bia_pkg::WORD_BITS-1:0] word,
  output logic                          found,
  output logic [bia_pkg::BIT_W-1:0]     idx
);
  import bia_pkg::*;

  // Scan from the top so the lowest clear bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        idx   = BIT_W'(i);
      end
    end
  end

endmodule

### design/bia_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_store: bitmap and summary storage
// Bitmap of 1024 x 32 in-use bits and a 32 x 32 summary whose bit j of row r
// marks bitmap word 32r+j as full. One access per store per cycle, read
// data registered (old data on a write).
// ----------------------------------------------------------------------------
module bia_store (
  input  logic                          clk,
  input  bia_pkg::mem_req_t             req,
  output logic [bia_pkg::WORD_BITS-1:0] data_rdata,
  output logic [bia_pkg::WORD_BITS-1:0] sum_rdata
);
  import bia_pkg::*;

  logic [WORD_BITS-1:0] data_mem [STORE_WORDS];
  logic [WORD_BITS-1:0] sum_mem  [ROWS];

  // Bitmap words
  always_ff @(posedge clk) begin
    if (req.data_we) begin
      data_mem[req.data_addr] <= req.data_wdata;
    end
    data_rdata <= data_mem[req.data_addr];
  end

  // Full-word summary rows
  always_ff @(posedge clk) begin
    if (req.sum_we) begin
      sum_mem[req.sum_addr] <= req.sum_wdata;
    end
    sum_rdata <= sum_mem[req.sum_addr];
  end

endmodule

### design/bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator: first-fit identifier allocator
// Allocates the lowest free identifier from a bitmap and releases given ones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap clear, one word a cycle, before it
// takes the first request (id_base may be written at any time). A request is
// taken while the block is idle and the block then stays busy: an allocate
// searches the row flags, reads the summary row, then reads the bitmap word
// and updates it, and a release reads the bitmap word and summary row and
// updates them, with one search unit finding the lowest clear bit at each
// level and one access per cycle to each store. An allocate that finds the
// map full, or a release outside id_base .. id_base + map size - 1, goes
// straight to its result and changes nothing. The result waits in an
// output register, so the next request is taken while it is still waiting.
// ----------------------------------------------------------------------------
module bitmap_id_allocator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bia_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bia_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata
);
  import bia_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_SUM = 4'd2;
  localparam logic [3:0] S_A_COL = 4'd3;
  localparam logic [3:0] S_A_DRD = 4'd4;
  localparam logic [3:0] S_A_BIT = 4'd5;
  localparam logic [3:0] S_R_RD  = 4'd6;
  localparam logic [3:0] S_R_WR  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [WADDR_W-1:0]   clr_cnt;
  logic [14:0]          id_base;
  logic [ROWS-1:0]      row_full;
  logic [RADDR_W-1:0]   row;
  logic [BIT_W-1:0]     col;
  logic [BIT_W-1:0]     bsel;
  out_word_t            res;

  mem_req_t             req;
  logic [WORD_BITS-1:0] data_rdata;
  logic [WORD_BITS-1:0] sum_rdata;

  logic [WORD_BITS-1:0] ffz_word;
  logic                 ffz_found;
  logic [BIT_W-1:0]     ffz_idx;

  logic                 accept;
  logic [16:0]          rel_pos;
  logic                 rel_bad;
  logic [16:0]          alloc_pos;
  logic                 alloc_ok;
  logic [WORD_BITS-1:0] set_word;
  logic [WORD_BITS-1:0] set_row;
  logic                 emit_load;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign emit_load = (state == S_EMIT) && (!out_valid || out_ready);

  // Release position and range check
  assign rel_pos = {1'b0, in_data.release_id} - {2'b00, id_base};
  assign rel_bad = rel_pos[16] || (rel_pos >= MAP_BITS_W);

  // Candidate position of an allocate and its updated word and summary row
  assign alloc_pos = {2'b00, row, col, ffz_idx};
  assign alloc_ok  = alloc_pos < MAP_BITS_W;
  assign set_word  = data_rdata | (WORD_BITS'(1) << ffz_idx);
  assign set_row   = sum_rdata | (WORD_BITS'(1) << col);

  // Select the operand of the shared search unit
  always_comb begin
    case (state)
      S_A_COL: ffz_word = sum_rdata;
      S_A_BIT: ffz_word = data_rdata;
      default: ffz_word = row_full;
    endcase
  end

  bia_ffz u_ffz (
    .word  (ffz_word),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  // Drive the store accesses
  always_comb begin
    req.data_we    = 1'b0;
    req.data_addr  = {row, col};
    req.data_wdata = '0;
    req.sum_we     = 1'b0;
    req.sum_addr   = row;
    req.sum_wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        req.data_we   = 1'b1;
        req.data_addr = clr_cnt;
        req.sum_we    = 1'b1;
        req.sum_addr  = clr_cnt[RADDR_W-1:0];
      end
      S_A_BIT: begin
        if (alloc_ok) begin
          req.data_we    = 1'b1;
          req.data_wdata = set_word;
          if (&set_word) begin
            req.sum_we    = 1'b1;
            req.sum_wdata = set_row;
          end
        end
      end
      S_R_WR: begin
        req.data_we    = 1'b1;
        req.data_wdata = data_rdata & ~(WORD_BITS'(1) << bsel);
        req.sum_we     = 1'b1;
        req.sum_wdata  = sum_rdata & ~(WORD_BITS'(1) << col);
      end
      default: begin
      end
    endcase
  end

  bia_store u_store (
    .clk        (clk),
    .req        (req),
    .data_rdata (data_rdata),
    .sum_rdata  (sum_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (&clr_cnt) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_RELEASE) begin
            state_next = rel_bad ? S_EMIT : S_R_RD;
          end else begin
            state_next = ffz_found ? S_A_SUM : S_EMIT;
          end
        end
      end
      S_A_SUM: state_next = S_A_COL;
      S_A_COL: state_next = S_A_DRD;
      S_A_DRD: state_next = S_A_BIT;
      S_A_BIT: state_next = S_EMIT;
      S_R_RD:  state_next = S_R_WR;
      S_R_WR:  state_next = S_EMIT;
      S_EMIT: begin
        if (emit_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      id_base   <= '0;
      row_full  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        id_base <= cfg_wdata;
      end
      // Mark a row full when its last free word fills, free it on release
      if (state == S_A_BIT && alloc_ok && (&set_word) && (&set_row)) begin
        row_full[row] <= 1'b1;
      end else if (state == S_R_WR) begin
        row_full[row] <= 1'b0;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Position and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_data.mode == MODE_RELEASE) begin
          row  <= rel_pos[14:10];
          col  <= rel_pos[9:5];
          bsel <= rel_pos[4:0];
          res  <= '{granted_id: 16'd0, status: rel_bad ? ST_RANGE : ST_OK};
        end else begin
          row <= ffz_idx;
          res <= '{granted_id: 16'd0, status: ST_FULL};
        end
      end
      S_A_COL: col <= ffz_idx;
      S_A_BIT: begin
        if (alloc_ok) begin
          res <= '{granted_id: {1'b0, id_base} + alloc_pos[15:0], status: ST_OK};
        end else begin
          res <= '{granted_id: 16'd0, status: ST_FULL};
        end
      end
      default: begin
      end
    endcase
    if (emit_load) begin
      out_data <= res;
    end
  end

endmodule

### dv/bitmap_id_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_tb: self-checking bench for the first-fit id allocator
// Drives allocate and release words from a queue and keeps its own bitmap to
// predict every result word. It covers directed corner cases, mixed random
// traffic over several id_base settings, a long output stall, releases
// spread over the whole map, and a last stretch without idling.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_tb;
  import bia_pkg::*;

  localparam int unsigned SCAN_WORDS  = ((MAP_BITS + 31) / 32 < STORE_WORDS) ?
                                        (MAP_BITS + 31) / 32 : STORE_WORDS;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 400;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [14:0] cfg_wdata = '0;

  // Own copy of the allocator state
  bit [31:0]   used_map [STORE_WORDS];
  int unsigned id_base_now = 0;
  int unsigned first_open  = 0;

  in_word_t    requests_todo [$];
  out_word_t   results_due [$];

  logic        in_fire         = 1'b0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_gap        = 0;
  int unsigned hold_left       = 0;
  int unsigned idle_pct        = 0;
  bit          long_hold_armed = 1'b0;
  bit          long_hold_done  = 1'b0;
  int unsigned phase_base      = 0;

  int unsigned fail_count    = 0;
  int unsigned n_grant       = 0;
  int unsigned n_full        = 0;
  int unsigned n_range       = 0;
  int unsigned n_freed       = 0;
  int unsigned n_base_writes = 0;

  bitmap_id_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Apply one request to the bitmap copy and return the word it yields
  function automatic out_word_t allocate_or_release(in_word_t req);
    out_word_t   res;
    int unsigned w;
    int unsigned b;
    int unsigned pos;
    int unsigned rid;
    res = '0;
    if (req.mode == MODE_ALLOC) begin
      // every word below first_open is known to be full
      w = first_open;
      while (w < SCAN_WORDS && used_map[w] == 32'hFFFF_FFFF) w++;
      first_open = w;
      res.status = ST_FULL;
      if (w < SCAN_WORDS) begin
        b = 0;
        while (used_map[w][b]) b++;
        pos = w * 32 + b;
        if (pos < MAP_BITS) begin
          used_map[w][b] = 1'b1;
          res.granted_id = 16'(id_base_now + pos);
          res.status     = ST_OK;
        end
      end
      if (res.status == ST_OK) n_grant++;
      else n_full++;
    end else begin
      rid = req.release_id;
      if (rid < id_base_now || rid - id_base_now >= MAP_BITS) begin
        res.status = ST_RANGE;
        n_range++;
      end else begin
        pos = rid - id_base_now;
        w   = (pos >> 5) & (STORE_WORDS - 1);
        used_map[w][pos & 31] = 1'b0;
        if (w < first_open) first_open = w;
        res.status = ST_OK;
        n_freed++;
      end
    end
    return res;
  endfunction

  // Sample both handshakes, check results and predict new ones
  always @(posedge clk) begin
    out_word_t due;
    in_fire <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (cfg_we) id_base_now = cfg_wdata;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with none outstanding: granted_id %0d status %0d",
                 out_data.granted_id, out_data.status);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (out_data.granted_id !== due.granted_id) begin
            $error("granted_id mismatch: expected %0d, actual %0d",
                   due.granted_id, out_data.granted_id);
            fail_count++;
          end
          if (out_data.status !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   due.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) results_due.push_back(allocate_or_release(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer request words, with random bursts of idling
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (requests_todo.size() != 0 && idle_pct != 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 8);
      end else if (requests_todo.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= requests_todo.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accept result words; hold off in bursts, once for a long stretch
  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold_armed && !long_hold_done) begin
        out_ready      <= 1'b0;
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stop the run if the handshakes stall for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("bitmap_id_allocator_tb failed");
    $finish;
  end

  task automatic write_base(input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 15'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    phase_base = value;
    n_base_writes++;
  endtask

  task automatic push_req(input logic mode, input int unsigned id);
    in_word_t req;
    req.mode       = mode;
    req.release_id = 16'(id);
    requests_todo.push_back(req);
  endtask

  // Mostly allocates and releases near the base, some raw release noise
  task automatic push_mix(input int count, input int unsigned alloc_pct,
                          input int unsigned span);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) push_req(MODE_ALLOC, $urandom_range(0, 65535));
      else if (r < 93) push_req(MODE_RELEASE, phase_base + $urandom_range(0, span));
      else push_req(MODE_RELEASE, $urandom_range(0, 65535));
    end
  endtask

  task automatic drain();
    while (requests_todo.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct = 20;

    // Base zero: first grants, free and out-of-range releases
    write_base(0);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_ALLOC, 65535);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_RELEASE, 1);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_RELEASE, 100);
    push_req(MODE_RELEASE, 32768);
    push_req(MODE_RELEASE, 65535);
    push_req(MODE_RELEASE, 0);
    push_req(MODE_ALLOC, 0);
    drain();

    // Top base with bits still set: below-base, past-map and edge releases
    write_base(32767);
    push_req(MODE_ALLOC, 0);
    push_req(MODE_RELEASE, 32766);
    push_req(MODE_RELEASE, 0);
    push_req(MODE_RELEASE, 65534);
    push_req(MODE_RELEASE, 65535);
    push_req(MODE_RELEASE, 32768);
    push_req(MODE_ALLOC, 65535);
    drain();

    // Random traffic over a few bases
    idle_pct = 30;
    write_base($urandom_range(1, 32766));
    push_mix(600, 55, 63);
    drain();

    idle_pct = 10;
    write_base(0);
    push_mix(500, 55, 127);
    drain();

    // Hold the output long enough for the input to back up
    idle_pct = 20;
    write_base($urandom_range(0, 32767));
    push_mix(100, 50, 31);
    long_hold_armed = 1'b1;
    drain();

    // Spread releases across the whole map
    idle_pct = 25;
    write_base($urandom_range(0, 32767));
    push_mix(400, 50, 32767);
    drain();

    // Last stretch without idling
    idle_pct = 0;
    write_base($urandom_range(0, 32767));
    push_mix(400, 50, 255);
    drain();

    repeat (16) @(posedge clk);
    $display("covered %0d grants, %0d full-map refusals, %0d in-range releases, %0d %s",
             n_grant, n_full, n_freed, n_range, "out-of-range releases");
    $display("over %0d id_base settings incl. 0 and 32767 and a long output stall",
             n_base_writes);
    if (fail_count == 0) begin
      $display("bitmap_id_allocator_tb passed");
    end else begin
      $display("bitmap_id_allocator_tb failed");
    end
    $finish;
  end

endmodule

### bitmap_id_allocator.f
design/bia_pkg.sv
design/bia_ffz.sv
design/bia_store.sv
design/bitmap_id_allocator.sv
dv/bitmap_id_allocator_tb.sv
